>>> rtl/bfr_pkg.sv
// Package for the backlight fade ramp: widths, codes, payload words and the
// sequencer and shared-unit types. No dependencies.
package bfr_pkg;

    localparam int LEVEL_BITS   = 16;
    localparam int TIME_BITS    = 20;
    localparam int REG_BITS     = 10;
    localparam int ELAPSED_BITS = TIME_BITS + 1;
    localparam int ALU_BITS     = ((TIME_BITS > LEVEL_BITS) ? TIME_BITS : LEVEL_BITS) + 2;
    localparam int WORK_BITS    = TIME_BITS + LEVEL_BITS;
    localparam int CNT_BITS     = $clog2(LEVEL_BITS);

    localparam logic [REG_BITS-1:0] TICK_PERIOD_RESET = 10'd20;
    localparam logic [REG_BITS-1:0] MIN_FADE_RESET    = 10'd20;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_SET  = 1'b1;

    typedef enum logic [0:0] {
        CFG_TICK_PERIOD = 1'b0,
        CFG_MIN_FADE    = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic                  cmd;
        logic [LEVEL_BITS-1:0] target_level;
        logic [TIME_BITS-1:0]  fade_ms;
    } req_t;

    typedef struct packed {
        logic [LEVEL_BITS-1:0] level;
        logic                  fading;
    } rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SET,
        S_ADV,
        S_CMP,
        S_SPAN1,
        S_SPAN2,
        S_MUL,
        S_DIV,
        S_RND,
        S_LVL,
        S_OUT
    } state_t;

    typedef enum logic [3:0] {
        ALU_NOP,
        ALU_ADV,
        ALU_CMP,
        ALU_SPAN_UP,
        ALU_SPAN_DN,
        ALU_MUL,
        ALU_DIV,
        ALU_RND,
        ALU_LVL
    } alu_op_t;

    typedef struct packed {
        logic [ELAPSED_BITS-1:0] elapsed;
        logic [TIME_BITS-1:0]    duration;
        logic [REG_BITS-1:0]     tick_period;
        logic [LEVEL_BITS-1:0]   start_level;
        logic [LEVEL_BITS-1:0]   end_level;
        logic [WORK_BITS-1:0]    work;
        logic                    down;
        logic                    rnd;
    } alu_in_t;

    typedef struct packed {
        logic [ALU_BITS-1:0] sum;
        logic                carry;
    } alu_out_t;

endpackage

>>> rtl/bfr_alu.sv
// Shared add/subtract unit of the backlight fade ramp: operand select per
// micro-op, one adder with invert and carry-in. Depends on bfr_pkg.
module bfr_alu
(
    input  bfr_pkg::alu_op_t  op,
    input  bfr_pkg::alu_in_t  opnd,
    output bfr_pkg::alu_out_t res
);

    localparam int AW = bfr_pkg::ALU_BITS;
    localparam int LB = bfr_pkg::LEVEL_BITS;
    localparam int TB = bfr_pkg::TIME_BITS;
    localparam int WB = bfr_pkg::WORK_BITS;

    logic [AW-1:0] a;
    logic [AW-1:0] b;
    logic          inv;
    logic          cin;
    logic [AW:0]   total;

    always_comb
    begin
        a   = '0;
        b   = '0;
        inv = 1'b0;
        cin = 1'b0;
        case (op)
            bfr_pkg::ALU_ADV:
            begin
                a = AW'(opnd.elapsed);
                b = AW'(opnd.tick_period);
            end
            bfr_pkg::ALU_CMP:
            begin
                a   = AW'(opnd.elapsed);
                b   = AW'(opnd.duration);
                inv = 1'b1;
                cin = 1'b1;
            end
            bfr_pkg::ALU_SPAN_UP:
            begin
                a   = AW'(opnd.end_level);
                b   = AW'(opnd.start_level);
                inv = 1'b1;
                cin = 1'b1;
            end
            bfr_pkg::ALU_SPAN_DN:
            begin
                a   = AW'(opnd.start_level);
                b   = AW'(opnd.end_level);
                inv = 1'b1;
                cin = 1'b1;
            end
            bfr_pkg::ALU_MUL:
            begin
                // add the multiplicand into the high half when the low bit is set
                a = AW'(opnd.work[WB-1:LB]);
                b = opnd.work[0] ? AW'(opnd.elapsed[TB-1:0]) : '0;
            end
            bfr_pkg::ALU_DIV:
            begin
                // trial subtract of the shifted partial remainder
                a   = AW'(opnd.work[WB-1:LB-1]);
                b   = AW'(opnd.duration);
                inv = 1'b1;
                cin = 1'b1;
            end
            bfr_pkg::ALU_RND:
            begin
                // twice the remainder against the divisor
                a   = AW'({opnd.work[WB-1:LB], 1'b0});
                b   = AW'(opnd.duration);
                inv = 1'b1;
                cin = 1'b1;
            end
            bfr_pkg::ALU_LVL:
            begin
                // start + q + rnd, or start - q - rnd as start + ~q + !rnd
                a   = AW'(opnd.start_level);
                b   = AW'(opnd.work[LB-1:0]);
                inv = opnd.down;
                cin = opnd.down ? !opnd.rnd : opnd.rnd;
            end
            default:
            begin
                a = '0;
            end
        endcase
        total = {1'b0, a} + {1'b0, (inv ? ~b : b)} + (AW + 1)'(cin);
    end

    assign res.sum   = total[AW-1:0];
    assign res.carry = total[AW];

endmodule

>>> rtl/backlight_fade_ramp.sv
// Top level of the backlight fade ramp: handshakes, configuration registers,
// fade state and the sequencer. Depends on bfr_pkg and bfr_alu.
//
// Holds a backlight level and moves it to a requested target, either at once
// or by a linear fade that timer-tick words advance. Every accepted request
// word yields exactly one response word with the level and a fading flag.
// The block handles one word at a time and holds req_stall high until that
// word's response is loaded into the output register; a waiting response
// does not block the next request, only the final write of the one after it.
// A tick inside a fade advances the elapsed time, compares it with the
// duration and takes the span, all on the single shared adder, then does
// one shift-add multiply step per cycle for elapsed*span, then one restoring
// divide step per cycle for the quotient by the duration, then rounding and
// the level; a set command, a tick while idle and a tick that ends the fade
// skip that arithmetic.
// Configuration writes are always taken (cfg_ready stays high) and must only
// arrive while the block is idle.
module backlight_fade_ramp
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 req_valid,
    output logic                                 req_stall,
    input  bfr_pkg::req_t                        req,
    output logic                                 rsp_valid,
    input  logic                                 rsp_stall,
    output bfr_pkg::rsp_t                        rsp,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  bfr_pkg::cfg_idx_t                    cfg_index,
    input  logic [bfr_pkg::REG_BITS-1:0]         cfg_data
);

    localparam int LB = bfr_pkg::LEVEL_BITS;
    localparam int TB = bfr_pkg::TIME_BITS;
    localparam int EB = bfr_pkg::ELAPSED_BITS;
    localparam int AW = bfr_pkg::ALU_BITS;
    localparam int WB = bfr_pkg::WORK_BITS;
    localparam int CB = bfr_pkg::CNT_BITS;

    // sequencer and architectural state
    bfr_pkg::state_t        state_reg, state_next;
    bfr_pkg::req_t          req_reg, req_next;
    logic [LB-1:0]          cur_level_reg, cur_level_next;
    logic [LB-1:0]          start_level_reg, start_level_next;
    logic [LB-1:0]          end_level_reg, end_level_next;
    logic [EB-1:0]          elapsed_reg, elapsed_next;
    logic [TB-1:0]          duration_reg, duration_next;
    logic                   fade_active_reg, fade_active_next;
    logic                   down_reg, down_next;
    logic                   rnd_reg, rnd_next;
    logic [WB-1:0]          work_reg, work_next;
    logic [CB-1:0]          cnt_reg, cnt_next;
    logic                   rsp_valid_reg, rsp_valid_next;
    bfr_pkg::rsp_t          rsp_reg, rsp_next;

    // configuration
    logic [bfr_pkg::REG_BITS-1:0] tick_period_reg;
    logic [bfr_pkg::REG_BITS-1:0] min_fade_reg;

    logic                   req_accept;
    logic                   cnt_last;
    bfr_pkg::alu_op_t       alu_op;
    bfr_pkg::alu_in_t       alu_in;
    bfr_pkg::alu_out_t      alu_res;

    assign req_stall  = (state_reg != bfr_pkg::S_IDLE);
    assign req_accept = req_valid && !req_stall;
    assign rsp_valid  = rsp_valid_reg;
    assign rsp        = rsp_reg;
    assign cfg_ready  = 1'b1;
    assign cnt_last   = (cnt_reg == CB'(LB - 1));

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_period_reg <= bfr_pkg::TICK_PERIOD_RESET;
            min_fade_reg    <= bfr_pkg::MIN_FADE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                bfr_pkg::CFG_TICK_PERIOD: tick_period_reg <= cfg_data;
                bfr_pkg::CFG_MIN_FADE:    min_fade_reg    <= cfg_data;
                default:                  tick_period_reg <= tick_period_reg;
            endcase
        end
    end

    // shared arithmetic unit
    assign alu_in.elapsed     = elapsed_reg;
    assign alu_in.duration    = duration_reg;
    assign alu_in.tick_period = tick_period_reg;
    assign alu_in.start_level = start_level_reg;
    assign alu_in.end_level   = end_level_reg;
    assign alu_in.work        = work_reg;
    assign alu_in.down        = down_reg;
    assign alu_in.rnd         = rnd_reg;

    bfr_alu u_alu
    (
        .op   (alu_op),
        .opnd (alu_in),
        .res  (alu_res)
    );

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= bfr_pkg::S_IDLE;
            cur_level_reg   <= '0;
            start_level_reg <= '0;
            end_level_reg   <= '0;
            elapsed_reg     <= '0;
            duration_reg    <= '0;
            fade_active_reg <= 1'b0;
            down_reg        <= 1'b0;
            rnd_reg         <= 1'b0;
            cnt_reg         <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cur_level_reg   <= cur_level_next;
            start_level_reg <= start_level_next;
            end_level_reg   <= end_level_next;
            elapsed_reg     <= elapsed_next;
            duration_reg    <= duration_next;
            fade_active_reg <= fade_active_next;
            down_reg        <= down_next;
            rnd_reg         <= rnd_next;
            cnt_reg         <= cnt_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        work_reg <= work_next;
        rsp_reg  <= rsp_next;
    end

    // sequencer: next state and datapath control
    always_comb
    begin
        state_next       = state_reg;
        req_next         = req_reg;
        cur_level_next   = cur_level_reg;
        start_level_next = start_level_reg;
        end_level_next   = end_level_reg;
        elapsed_next     = elapsed_reg;
        duration_next    = duration_reg;
        fade_active_next = fade_active_reg;
        down_next        = down_reg;
        rnd_next         = rnd_reg;
        work_next        = work_reg;
        cnt_next         = cnt_reg;
        rsp_next         = rsp_reg;
        rsp_valid_next   = rsp_valid_reg;
        alu_op           = bfr_pkg::ALU_NOP;

        // drop the response once the consumer takes it
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            bfr_pkg::S_IDLE:
            begin
                if (req_accept)
                begin
                    req_next = req;
                    if (req.cmd == bfr_pkg::CMD_SET)
                    begin
                        state_next = bfr_pkg::S_SET;
                    end
                    else if (fade_active_reg)
                    begin
                        state_next = bfr_pkg::S_ADV;
                    end
                    else
                    begin
                        // tick while idle: report the level unchanged
                        state_next = bfr_pkg::S_OUT;
                    end
                end
            end
            bfr_pkg::S_SET:
            begin
                if (req_reg.target_level == cur_level_reg)
                begin
                    // cancel: stop any fade where it stands
                    fade_active_next = 1'b0;
                    elapsed_next     = '0;
                    duration_next    = '0;
                    start_level_next = cur_level_reg;
                    end_level_next   = cur_level_reg;
                end
                else if (AW'(req_reg.fade_ms) <= AW'(min_fade_reg))
                begin
                    // short fade: apply the target at once
                    cur_level_next   = req_reg.target_level;
                    fade_active_next = 1'b0;
                    elapsed_next     = '0;
                    duration_next    = '0;
                    start_level_next = req_reg.target_level;
                    end_level_next   = req_reg.target_level;
                end
                else
                begin
                    // start a new fade from the level reached so far
                    start_level_next = cur_level_reg;
                    end_level_next   = req_reg.target_level;
                    elapsed_next     = '0;
                    duration_next    = req_reg.fade_ms;
                    fade_active_next = 1'b1;
                end
                state_next = bfr_pkg::S_OUT;
            end
            bfr_pkg::S_ADV:
            begin
                // advance elapsed time, saturating at its maximum
                alu_op = bfr_pkg::ALU_ADV;
                if (|alu_res.sum[AW-1:EB])
                begin
                    elapsed_next = '1;
                end
                else
                begin
                    elapsed_next = alu_res.sum[EB-1:0];
                end
                state_next = bfr_pkg::S_CMP;
            end
            bfr_pkg::S_CMP:
            begin
                alu_op = bfr_pkg::ALU_CMP;
                if (alu_res.carry)
                begin
                    // fade time used up: land on the target
                    cur_level_next   = end_level_reg;
                    fade_active_next = 1'b0;
                    state_next       = bfr_pkg::S_OUT;
                end
                else
                begin
                    state_next = bfr_pkg::S_SPAN1;
                end
            end
            bfr_pkg::S_SPAN1:
            begin
                alu_op = bfr_pkg::ALU_SPAN_UP;
                if (alu_res.carry)
                begin
                    down_next  = 1'b0;
                    work_next  = WB'(alu_res.sum[LB-1:0]);
                    cnt_next   = '0;
                    state_next = bfr_pkg::S_MUL;
                end
                else
                begin
                    down_next  = 1'b1;
                    state_next = bfr_pkg::S_SPAN2;
                end
            end
            bfr_pkg::S_SPAN2:
            begin
                alu_op     = bfr_pkg::ALU_SPAN_DN;
                work_next  = WB'(alu_res.sum[LB-1:0]);
                cnt_next   = '0;
                state_next = bfr_pkg::S_MUL;
            end
            bfr_pkg::S_MUL:
            begin
                // one shift-add step of elapsed * span
                alu_op    = bfr_pkg::ALU_MUL;
                work_next = {alu_res.sum[TB:0], work_reg[LB-1:1]};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_last)
                begin
                    cnt_next   = '0;
                    state_next = bfr_pkg::S_DIV;
                end
            end
            bfr_pkg::S_DIV:
            begin
                // one restoring divide step by the duration
                alu_op = bfr_pkg::ALU_DIV;
                if (alu_res.carry)
                begin
                    work_next = {alu_res.sum[TB-1:0], work_reg[LB-2:0], 1'b1};
                end
                else
                begin
                    work_next = {work_reg[WB-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_last)
                begin
                    cnt_next   = '0;
                    state_next = bfr_pkg::S_RND;
                end
            end
            bfr_pkg::S_RND:
            begin
                // round half away from zero on the magnitude
                alu_op     = bfr_pkg::ALU_RND;
                rnd_next   = alu_res.carry;
                state_next = bfr_pkg::S_LVL;
            end
            bfr_pkg::S_LVL:
            begin
                alu_op         = bfr_pkg::ALU_LVL;
                cur_level_next = alu_res.sum[LB-1:0];
                state_next     = bfr_pkg::S_OUT;
            end
            bfr_pkg::S_OUT:
            begin
                // hold until the output register is free
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next.level  = cur_level_reg;
                    rsp_next.fading = fade_active_reg;
                    state_next      = bfr_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bfr_pkg::S_IDLE;
            end
        endcase
    end

    // the sequencer only leaves idle on an accepted word
    a_idle_hold : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bfr_pkg::S_IDLE && !req_accept) |=> (state_reg == bfr_pkg::S_IDLE))
        else $error("sequencer left idle without a request word");

    // interpolation runs only inside an active fade
    a_interp_active : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bfr_pkg::S_MUL || state_reg == bfr_pkg::S_DIV ||
         state_reg == bfr_pkg::S_RND || state_reg == bfr_pkg::S_LVL) |-> fade_active_reg)
        else $error("interpolation step outside an active fade");

    // partial remainder stays below the divisor
    a_div_rem : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bfr_pkg::S_DIV || state_reg == bfr_pkg::S_RND) |->
        (work_reg[WB-1:LB] < duration_reg))
        else $error("divide remainder out of range");

    // interpolation only while elapsed time is short of the duration
    a_elapsed_short : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bfr_pkg::S_SPAN1) |-> (elapsed_reg < EB'(duration_reg)))
        else $error("interpolation started with elapsed past duration");

    // a finished word is loaded into the output register
    a_out_load : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bfr_pkg::S_OUT && !(rsp_valid_reg && rsp_stall)) |=>
        (rsp_valid_reg && state_reg == bfr_pkg::S_IDLE))
        else $error("response word not loaded");

endmodule
